// ===== hdl/rvimm_pkg.sv =====
package rvimm_pkg;

    localparam int XLEN          = 32;
    localparam int REG_IDX_W     = 5;
    localparam int REG_COUNT_DEF = 32;

    localparam logic [6:0] OPC_OPIMM = 7'h13;
    localparam logic [6:0] OPC_LUI   = 7'h37;
    localparam logic [6:0] OPC_AUIPC = 7'h17;

    // imm[11:5] for the shift-immediate forms
    localparam logic [6:0] FUNCT7_LOGICAL = 7'b0000000;
    localparam logic [6:0] FUNCT7_ARITH   = 7'b0100000;

    typedef enum logic [2:0] {
        F3_ADDI  = 3'd0,
        F3_SLLI  = 3'd1,
        F3_SLTI  = 3'd2,
        F3_SLTIU = 3'd3,
        F3_XORI  = 3'd4,
        F3_SRI   = 3'd5,
        F3_ORI   = 3'd6,
        F3_ANDI  = 3'd7
    } funct3_t;

endpackage

// ===== hdl/rv32i_immediate_alu_execute_unit.sv =====
// An input transfer loads the input register; it is then executed into the result register offered on m_valid.
// Throughput: one instruction per cycle while m_ready is high; the register file is read from the input
// register and written as the result register loads, so back-to-back dependent
// instructions see the updated value.
// Reset (aresetn low, synchronous): both pipeline stages empty, all register-file entries zero.
module rv32i_immediate_alu_execute_unit #(
    parameter int REG_COUNT = rvimm_pkg::REG_COUNT_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [rvimm_pkg::XLEN-1:0]        s_instruction,
    input  logic [rvimm_pkg::XLEN-1:0]        s_instr_address,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [rvimm_pkg::REG_IDX_W-1:0]   m_dest_index,
    output logic [rvimm_pkg::XLEN-1:0]        m_write_value,
    output logic                              m_wrote,
    output logic                              m_status
);
    import rvimm_pkg::*;

    localparam int IDX_W = $clog2(REG_COUNT);
    localparam logic [REG_IDX_W:0] REG_LIMIT = (REG_IDX_W+1)'(REG_COUNT);

    // input stage
    logic             in_valid_reg;
    logic [XLEN-1:0]  instr_reg;
    logic [XLEN-1:0]  pc_reg;

    // result stage
    logic                 out_valid_reg;
    logic [REG_IDX_W-1:0] dest_reg;
    logic [XLEN-1:0]      value_reg;
    logic                 wrote_reg;
    logic                 status_reg;

    logic [XLEN-1:0] regfile_reg [REG_COUNT];

    logic advance;

    // execute
    logic [6:0]           opc;
    logic [REG_IDX_W-1:0] rd;
    logic [REG_IDX_W-1:0] rs1;
    funct3_t              f3;
    logic [XLEN-1:0]      imm;
    logic [4:0]           shamt;
    logic [6:0]           f7;
    logic [XLEN-1:0]      a;
    logic [XLEN-1:0]      val;
    logic                 ok;
    logic                 wrote_next;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        opc   = instr_reg[6:0];
        rd    = instr_reg[11:7];
        f3    = funct3_t'(instr_reg[14:12]);
        rs1   = instr_reg[19:15];
        imm   = {{(XLEN-12){instr_reg[31]}}, instr_reg[31:20]};
        shamt = instr_reg[24:20];
        f7    = instr_reg[31:25];
        ok    = 1'b1;
        val   = '0;
        a     = '0;
        if ({1'b0, rs1} < REG_LIMIT) begin
            a = regfile_reg[rs1[IDX_W-1:0]];
        end
        unique case (opc)
            OPC_OPIMM: begin
                if ({1'b0, rs1} >= REG_LIMIT) begin
                    ok = 1'b0;
                end
                unique case (f3)
                    F3_ADDI:  val = a + imm;
                    F3_SLLI: begin
                        if (f7 == FUNCT7_LOGICAL) begin
                            val = a << shamt;
                        end else begin
                            ok = 1'b0;
                        end
                    end
                    F3_SLTI:  val = {{(XLEN-1){1'b0}}, $signed(a) < $signed(imm)};
                    F3_SLTIU: val = {{(XLEN-1){1'b0}}, a < imm};
                    F3_XORI:  val = a ^ imm;
                    F3_SRI: begin
                        if (f7 == FUNCT7_LOGICAL) begin
                            val = a >> shamt;
                        end else if (f7 == FUNCT7_ARITH) begin
                            val = XLEN'($signed(a) >>> shamt);
                        end else begin
                            ok = 1'b0;
                        end
                    end
                    F3_ORI:   val = a | imm;
                    F3_ANDI:  val = a & imm;
                endcase
            end
            OPC_LUI:   val = {instr_reg[31:12], 12'b0};
            OPC_AUIPC: val = pc_reg + {instr_reg[31:12], 12'b0};
            default:   ok = 1'b0;
        endcase
        if ({1'b0, rd} >= REG_LIMIT) begin
            ok = 1'b0;
        end
        wrote_next = ok && (rd != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            instr_reg <= s_instruction;
            pc_reg    <= s_instr_address;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            dest_reg   <= rd;
            value_reg  <= wrote_next ? val : '0;
            wrote_reg  <= wrote_next;
            status_reg <= !ok;
        end
    end

    // x0 is never written, so it holds its reset zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < REG_COUNT; i++) begin
                regfile_reg[i] <= '0;
            end
        end else if (advance && wrote_next) begin
            regfile_reg[rd[IDX_W-1:0]] <= val;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_dest_index  = dest_reg;
    assign m_write_value = value_reg;
    assign m_wrote       = wrote_reg;
    assign m_status      = status_reg;

endmodule

// ===== hdl/rvimm_checker.sv =====
module rvimm_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [rvimm_pkg::REG_IDX_W-1:0] m_dest_index,
    input logic [rvimm_pkg::XLEN-1:0]      m_write_value,
    input logic                            m_wrote,
    input logic                            m_status
);
    import rvimm_pkg::*;

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_write_value) && $stable(m_dest_index))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result offered straight after reset");

    a_write_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_wrote |-> !m_status && (m_dest_index != '0))
        else $error("write reported with bad status or to x0");

    a_no_write_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_wrote |-> (m_write_value == '0))
        else $error("non-zero value without a write");

    // an empty pipeline always takes a transfer
    a_accept_after_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid && !$past(s_valid && s_ready) |-> s_ready)
        else $error("input stalled while pipeline empty");

endmodule

bind rv32i_immediate_alu_execute_unit rvimm_checker u_rvimm_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_dest_index  (m_dest_index),
    .m_write_value (m_write_value),
    .m_wrote       (m_wrote),
    .m_status      (m_status)
);
